// ----- rtl/butx_pkg.sv -----
// ---------------------------------------------------------------------------
// butx_pkg: shared types and constants of the buffered UART transmitter
// Beat formats of both channels, frame phase codes and the reload reset value.
// ---------------------------------------------------------------------------
package butx_pkg;

	// Default message buffer depth in bytes
	localparam int BUF_DEPTH_DEF = 256;

	// Register reset value: three ticks per bit
	localparam logic [7:0] RELOAD_RST = 8'd2;

	// Input command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Frame phase codes: start bit, data bits, stop bits
	localparam logic [3:0] PHASE_START     = 4'd1;
	localparam logic [3:0] PHASE_FIRST_DATA = 4'd2;
	localparam logic [3:0] PHASE_LAST_DATA = 4'd9;
	localparam logic [3:0] PHASE_STOP1     = 4'd10;
	localparam logic [3:0] PHASE_IDLE      = 4'd0;

	// Input beat
	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic tx_line;
		logic busy_res;
		logic load_rejected;
	} out_item_t;

endpackage

// ----- rtl/butx_buf_mem.sv -----
// ---------------------------------------------------------------------------
// butx_buf_mem: message byte buffer
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module butx_buf_mem import butx_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata_q
);

	logic [7:0] mem_q [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

// ----- rtl/butx_ctrl.sv -----
// ---------------------------------------------------------------------------
// butx_ctrl: load and frame control
// Append loaded bytes to the buffer, then step the bit timer and frame
// phase on ticks; produce one result beat per accepted item.
// ---------------------------------------------------------------------------
module butx_ctrl import butx_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	localparam int AW = $clog2(BUF_DEPTH),
	localparam int CW = $clog2(BUF_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  in_item_t      item,
	input  logic [7:0]    reload,
	input  logic [7:0]    cur_byte,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic [AW-1:0] mem_raddr,
	output out_item_t     result
);

	logic [CW-1:0] len_q, pos_q, fill_q;
	logic [7:0]    timer_q;
	logic [3:0]    phase_q;
	logic          line_q;

	logic [CW-1:0] len_d, pos_d, fill_d;
	logic [7:0]    timer_d;
	logic [3:0]    phase_d;
	logic          line_d;
	logic          rej_d;
	logic [CW-1:0] pos_inc;
	logic [2:0]    bit_sel;

	assign pos_inc   = pos_q + 1'b1;
	assign mem_raddr = pos_q[AW-1:0];
	assign mem_waddr = fill_q[AW-1:0];
	assign mem_wdata = item.data_byte;

	always_comb begin
		len_d   = len_q;
		pos_d   = pos_q;
		fill_d  = fill_q;
		timer_d = timer_q;
		phase_d = phase_q;
		line_d  = line_q;
		rej_d   = 1'b0;
		mem_we  = 1'b0;
		bit_sel = 3'(phase_q + 4'd1 - PHASE_FIRST_DATA);
		if (item.cmd == CMD_TICK) begin
			if (len_q != '0) begin
				if (timer_q != '0) begin
					timer_d = timer_q - 1'b1;
				end else begin
					// bit boundary: reload and advance the frame
					timer_d = reload;
					phase_d = phase_q + 1'b1;
					if (phase_d == PHASE_START) begin
						line_d = 1'b0;
					end else if (phase_d > PHASE_START && phase_d <= PHASE_LAST_DATA) begin
						line_d = cur_byte[bit_sel];
					end else if (phase_d == PHASE_STOP1) begin
						line_d = 1'b1;
					end else begin
						// first stop bit done: move to the next byte
						phase_d = PHASE_IDLE;
						pos_d   = pos_inc;
						if (pos_inc >= len_q) begin
							len_d = '0;
							pos_d = '0;
						end
					end
				end
			end
		end else begin
			if (len_q != '0) begin
				rej_d = 1'b1;
			end else begin
				if (fill_q < CW'(BUF_DEPTH)) begin
					mem_we = accept;
					fill_d = fill_q + 1'b1;
				end else begin
					rej_d = 1'b1;
				end
				if (item.last_byte && fill_d != '0) begin
					len_d  = fill_d;
					fill_d = '0;
					pos_d  = '0;
				end
			end
		end
	end

	assign result = '{tx_line: line_d, busy_res: (len_d != '0), load_rejected: rej_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
			timer_q <= '0;
			phase_q <= PHASE_IDLE;
			line_q  <= 1'b1;
		end else if (accept) begin
			len_q   <= len_d;
			pos_q   <= pos_d;
			fill_q  <= fill_d;
			timer_q <= timer_d;
			phase_q <= phase_d;
			line_q  <= line_d;
		end
	end

endmodule

// ----- rtl/butx_out_q.sv -----
// ---------------------------------------------------------------------------
// butx_out_q: two-entry result queue
// Output register plus skid stage; keeps input side open while a beat waits.
// ---------------------------------------------------------------------------
module butx_out_q import butx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      space,
	output logic      head_valid,
	input  logic      head_ready,
	output out_item_t head
);

	logic      head_v_q, skid_v_q;
	out_item_t head_q, skid_q;
	logic      pop;

	assign pop        = head_v_q & head_ready;
	assign space      = ~skid_v_q;
	assign head_valid = head_v_q;
	assign head       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			unique case ({push, pop})
				2'b10: begin
					if (head_v_q) skid_v_q <= 1'b1;
					else          head_v_q <= 1'b1;
				end
				2'b01: begin
					if (skid_v_q) skid_v_q <= 1'b0;
					else          head_v_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (head_v_q) skid_q <= push_data;
				else          head_q <= push_data;
			end
			2'b01: begin
				if (skid_v_q) head_q <= skid_q;
			end
			2'b11: begin
				if (skid_v_q) begin
					head_q <= skid_q;
					skid_q <= push_data;
				end else begin
					head_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/buffered_uart_transmitter.sv -----
// ---------------------------------------------------------------------------
// buffered_uart_transmitter: buffered 8N2 serial transmitter
// Collects a message in a byte buffer and shifts it out bit by bit, one
// bit per (bit_tick_reload + 1) tick beats, returning the line state.
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  item     | item_valid / item_ready     | cmd, data_byte, last_byte
//  result   | result_valid / result_ready | tx_line, busy_res, load_rejected
//  config   | cfg_we (no wait)            | cfg_wdata = bit_tick_reload
//
//  One item beat per clock while item_ready is high; its result beat is registered in the result queue.
//  The buffer read runs every cycle at the send position, so a byte is in
//  the read register well before its first data bit is needed.
//  item_ready drops only when both result slots (output register and skid)
//  are full; result stalls therefore cost nothing until the second beat.
//  Reset clears all counters, sets the line to idle mark and the reload to 2;
//  buffer contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module buffered_uart_transmitter import butx_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int AW = $clog2(BUF_DEPTH);

	logic [7:0]    reload_q;
	logic          accept;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;
	out_item_t     next_result;

	// Take an item beat whenever the result queue has a free slot
	assign accept = item_valid & item_ready;

	// Hold the bit timer reload; a write does not disturb a running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RST;
		end else if (cfg_we) begin
			reload_q <= cfg_wdata;
		end
	end

	// Message buffer: written by loads while idle, read at the send position
	butx_buf_mem #(.BUF_DEPTH(BUF_DEPTH)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	// Load bookkeeping, bit timer and frame sequencing
	butx_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.reload    (reload_q),
		.cur_byte  (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.result    (next_result)
	);

	// Result beats wait here until taken
	butx_out_q u_out_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (next_result),
		.space      (item_ready),
		.head_valid (result_valid),
		.head_ready (result_ready),
		.head       (result)
	);

endmodule

// ----- rtl/butx_checker.sv -----
// ---------------------------------------------------------------------------
// butx_checker: port-level checks of the buffered UART transmitter
// Watches both channels and flags lost, invented or malformed result beats.
// ---------------------------------------------------------------------------
module butx_checker import butx_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	logic [1:0] pend_q;
	logic       item_acc, res_acc;

	assign item_acc = item_valid & item_ready;
	assign res_acc  = result_valid & result_ready;

	// Track beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, item_acc} - {1'b0, res_acc};
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_idle_mark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> result.tx_line)
		else $error("line not at mark while idle");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result beat without an item");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> result_valid)
		else $error("no result beat after accepted item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !item_ready)
		else $error("item taken with both result slots full");

endmodule

bind buffered_uart_transmitter butx_checker u_butx_checker (.*);
